@@ rtl/core/rnmc_pkg.sv @@
// shared types, codes and helpers of the radix numeral converter
`default_nettype none
package rnmc_pkg;

  // input opcodes
  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_NOMAX = 2'd3;

  // command kinds passed from front to back
  localparam logic [2:0] K_DIGIT  = 3'd0;
  localparam logic [2:0] K_MINUS  = 3'd1;
  localparam logic [2:0] K_BAD    = 3'd2;
  localparam logic [2:0] K_END    = 3'd3;
  localparam logic [2:0] K_REPORT = 3'd4;

  // ascii
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] ALPHA_OFS  = 8'd55;

  localparam logic [5:0] BASE_MIN   = 6'd2;
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_RESET = 6'd10;
  localparam logic [5:0] DEC_DIGITS = 6'd10;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_char;
    logic [5:0] out_base;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               is_new_max;
    logic [7:0]         out_char;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] digit;
    logic [5:0] base;
  } cmd_t;

  function automatic logic [5:0] clamp_base(input logic [5:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    if (d < DEC_DIGITS) return {2'b00, d} + CHAR_ZERO;
    return {2'b00, d} + ALPHA_OFS;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rnmc_fifo.sv @@
// two-entry command queue between front and back
`default_nettype none
module rnmc_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rnmc_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output rnmc_pkg::cmd_t     pop_data,
  output logic               not_empty
);
  import rnmc_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/core/rnmc_front.sv @@
// front end: accepts input items and classifies characters into commands
`default_nettype none
module rnmc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [5:0]     in_base,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rnmc_pkg::in_item_t in_data,
  output logic                push,
  output rnmc_pkg::cmd_t      push_data,
  input  wire logic           q_full
);
  import rnmc_pkg::*;

  logic       at_first_char;
  logic       accept;
  logic       is_dec;
  logic       is_alpha;
  logic [5:0] digit;
  logic [5:0] base;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_data.opcode != OP_UNUSED);

  assign is_dec   = (in_data.in_char >= CHAR_ZERO) && (in_data.in_char <= CHAR_NINE);
  assign is_alpha = (in_data.in_char >= CHAR_UA) && (in_data.in_char <= CHAR_UZ);
  assign digit    = is_dec ? 6'(in_data.in_char - CHAR_ZERO)
                           : 6'(in_data.in_char - ALPHA_OFS);
  assign base     = clamp_base(in_base);

  always_comb begin
    push_data.digit = digit;
    push_data.base  = base;
    push_data.kind  = K_BAD;
    unique case (in_data.opcode)
      OP_CHAR: begin
        if (at_first_char && in_data.in_char == CHAR_MINUS) push_data.kind = K_MINUS;
        else if ((is_dec || is_alpha) && digit < base) push_data.kind = K_DIGIT;
        else push_data.kind = K_BAD;
      end
      OP_END: push_data.kind = K_END;
      OP_REPORT: begin
        push_data.kind = K_REPORT;
        push_data.base = clamp_base(in_data.out_base);
      end
      default: push_data.kind = K_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_char <= 1'b1;
    end else if (accept) begin
      if (in_data.opcode == OP_CHAR) at_first_char <= 1'b0;
      else if (in_data.opcode == OP_END) at_first_char <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rnmc_back.sv @@
// back end: accumulator, maximum tracking and digit-serial report engine
`default_nettype none
module rnmc_back #(
  parameter int ACC_W = 31
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire rnmc_pkg::cmd_t  cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rnmc_pkg::out_item_t  out_data
);
  import rnmc_pkg::*;

  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int IDX_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] BITS = CNT_W'(ACC_W);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [2:0]       state;
  logic [ACC_W-1:0] acc;
  logic             minus_seen;
  logic             bad_digit;
  logic             overflowed;
  logic [31:0]      max_value;
  logic             have_max;

  logic [ACC_W-1:0] dq;
  logic [5:0]       rem;
  logic [5:0]       div_base;
  logic [CNT_W-1:0] bitcnt;
  logic [CNT_W-1:0] ndig;
  logic [IDX_W-1:0] idx;
  logic [5:0]       dbuf [ACC_W];

  logic             out_free;
  logic             out_load;
  out_item_t        out_next;
  logic [ACC_W+5:0] nv;
  logic             nv_ovf;
  logic [31:0]      acc_ext;
  logic [31:0]      end_value;
  logic [31:0]      max_abs;
  logic [ACC_W-1:0] mag_max;
  logic             new_max;
  logic [6:0]       t;
  logic             ge;
  logic [5:0]       rem_step;
  logic [ACC_W-1:0] dq_step;
  logic             numeral_cmd;
  logic             div_done;

  assign out_free    = !out_valid || out_ready;
  assign numeral_cmd = (cmd.kind == K_DIGIT) || (cmd.kind == K_MINUS) || (cmd.kind == K_BAD);
  assign cmd_pop     = (state == S_IDLE) && cmd_valid && (numeral_cmd || out_free);

  // accumulate one digit
  assign nv     = ({6'b0, acc} * {{ACC_W{1'b0}}, cmd.base}) + {{ACC_W{1'b0}}, cmd.digit};
  assign nv_ovf = |nv[ACC_W+5:ACC_W];

  assign acc_ext   = {{(32-ACC_W){1'b0}}, acc};
  assign end_value = minus_seen ? (32'd0 - acc_ext) : acc_ext;
  assign max_abs   = max_value[31] ? (32'd0 - max_value) : max_value;
  assign mag_max   = max_abs[ACC_W-1:0];
  assign new_max   = !have_max || (acc > mag_max);

  // one restoring division step
  assign t        = {rem, dq[ACC_W-1]};
  assign ge       = (t >= {1'b0, div_base});
  assign rem_step = ge ? 6'(t - {1'b0, div_base}) : t[5:0];
  assign dq_step  = {dq[ACC_W-2:0], ge};
  assign div_done = (bitcnt == ONE);

  assign out_load = (cmd_pop && ((cmd.kind == K_END) || (cmd.kind == K_REPORT && !have_max)))
                 || ((state == S_SIGN || state == S_EMIT) && out_free);

  always_comb begin
    out_next.value      = max_value;
    out_next.status     = ST_OK;
    out_next.is_new_max = 1'b0;
    out_next.out_char   = digit_char(dbuf[idx]);
    out_next.last       = (idx == '0);
    if (state == S_IDLE) begin
      out_next.out_char = 8'd0;
      out_next.last     = 1'b1;
      if (cmd.kind == K_END) begin
        if (bad_digit) begin
          out_next.value  = 32'd0;
          out_next.status = ST_BAD;
        end else if (overflowed) begin
          out_next.value  = 32'd0;
          out_next.status = ST_OVF;
        end else begin
          out_next.value      = end_value;
          out_next.is_new_max = new_max;
        end
      end else begin
        out_next.value  = 32'd0;
        out_next.status = ST_NOMAX;
      end
    end else if (state == S_SIGN) begin
      out_next.out_char = CHAR_MINUS;
      out_next.last     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc        <= '0;
      minus_seen <= 1'b0;
      bad_digit  <= 1'b0;
      overflowed <= 1'b0;
      max_value  <= 32'd0;
      have_max   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.kind)
              K_MINUS: minus_seen <= 1'b1;
              K_BAD:   bad_digit <= 1'b1;
              K_DIGIT: begin
                if (!bad_digit && !overflowed) begin
                  if (nv_ovf) overflowed <= 1'b1;
                  else acc <= nv[ACC_W-1:0];
                end
              end
              K_END: begin
                if (!bad_digit && !overflowed && new_max) begin
                  max_value <= end_value;
                  have_max  <= 1'b1;
                end
                acc        <= '0;
                minus_seen <= 1'b0;
                bad_digit  <= 1'b0;
                overflowed <= 1'b0;
              end
              K_REPORT: if (have_max) state <= S_DIV;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done && dq_step == '0) state <= max_value[31] ? S_SIGN : S_EMIT;
        end
        S_SIGN: if (out_free) state <= S_EMIT;
        S_EMIT: if (out_free && idx == '0) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;
    unique case (state)
      S_IDLE: begin
        if (cmd_pop && cmd.kind == K_REPORT) begin
          dq       <= mag_max;
          rem      <= 6'd0;
          div_base <= cmd.base;
          bitcnt   <= BITS;
          ndig     <= '0;
        end
      end
      S_DIV: begin
        dq <= dq_step;
        if (div_done) begin
          dbuf[ndig[IDX_W-1:0]] <= rem_step;
          idx    <= ndig[IDX_W-1:0];
          ndig   <= ndig + ONE;
          rem    <= 6'd0;
          bitcnt <= BITS;
        end else begin
          rem    <= rem_step;
          bitcnt <= bitcnt - ONE;
        end
      end
      S_EMIT: if (out_free) idx <= idx - IDX_W'(1);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/radix_numeral_max_converter.sv @@
// top level of the radix numeral converter with maximum tracking
// usage:
//   input channel (in_valid/in_ready/in_data) takes one item per transfer:
//   a numeral character, an end of numeral, or a report request
//   output channel (out_valid/out_ready/out_data) gives result transfers:
//   one per end of numeral, one per report character or one if no maximum
//   in_base is set through the apb port at byte address 0; the user must
//   set it only while idle; the block itself does not enforce this
// flow:
//   front classifies each character and pushes a command into a
//   two-entry queue; the back pops one command a cycle while idle and,
//   for an end or report, only while the output register is free
//   character items give no result; end item: result valid the cycle
//   after the pop, the item passing queue entry then output register
//   report: a divider makes one quotient bit per cycle per digit; a minus
//   if negative, then the digits, most significant first, are sent
// reset: synchronous rst clears numeral state and maximum, in_base to 10
// stall: when out_ready is low the output register holds its transfer,
//   the back waits, the queue fills and then in_ready drops
`default_nettype none
module radix_numeral_max_converter #(
  parameter int MAG_BITS = 31
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // item input
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rnmc_pkg::in_item_t in_data,
  // result output
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rnmc_pkg::out_item_t  out_data,
  // configuration
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rnmc_pkg::*;

  // magnitude width, held to 31 bits so values fit the 32-bit result
  localparam int ACC_W = (MAG_BITS > 31) ? 31 : MAG_BITS;

  logic [5:0] in_base;
  logic       cfg_write;

  // front to queue
  logic       push;
  cmd_t       push_data;
  logic       q_full;

  // queue to back
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_pop;

  // register 0 lives at the low word; higher words read as zero
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {26'd0, in_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_base <= BASE_RESET;
    end else if (cfg_write) begin
      in_base <= pwdata[5:0];
    end
  end

  // classify characters, track first-character position
  rnmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_base   (in_base),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // decouples front from the multi-cycle back end
  rnmc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (cmd_pop),
    .pop_data  (cmd),
    .not_empty (cmd_valid)
  );

  // accumulate, track maximum, emit report characters
  rnmc_back #(
    .ACC_W (ACC_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
